// ----- sv/emacm_pkg.sv -----
`default_nettype none

package emacm_pkg;

  // Default build-time sizes
  localparam int CHANNELS_DEF   = 4;
  localparam int MIN_PASSES_DEF = 3;

  // EMA weights, alpha = 0.2 in Q0.16 (new + old = 65536)
  localparam logic [15:0] ALPHA_NEW = 16'd13107;
  localparam logic [15:0] ALPHA_OLD = 16'd52429;

  // Register reset values
  localparam logic [31:0] TOLERANCE_RST  = 32'd655;
  localparam logic [31:0] MAX_PASSES_RST = 32'd100;

  // Register map, selected by paddr[2]
  localparam int          CFG_ADDR_W     = 3;
  localparam logic        REG_TOLERANCE  = 1'b0;
  localparam logic        REG_MAX_PASSES = 1'b1;

  // Word kinds carried on in_tuser
  localparam logic        MODE_CHECK = 1'b0;
  localparam logic        MODE_CLEAR = 1'b1;

  // Stream payload widths
  localparam int IN_TDATA_W  = 72;
  localparam int OUT_TDATA_W = 72;

  typedef struct packed {
    logic        mode;
    logic [1:0]  channel;
    logic [31:0] current_value;
    logic [31:0] target_value;
  } in_word_t;

  typedef struct packed {
    logic [31:0] ema;
    logic [31:0] passes;
  } chan_state_t;

  typedef struct packed {
    logic        converged;
    logic [31:0] smoothed_residual;
    logic [31:0] pass_count;
  } result_t;

  typedef struct packed {
    logic [31:0] tolerance;
    logic [31:0] max_passes;
  } cfg_t;

endpackage

`default_nettype wire

// ----- sv/emacm_cfg_regs.sv -----
`default_nettype none

module emacm_cfg_regs (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                psel,
  input  wire logic                                penable,
  input  wire logic                                pwrite,
  input  wire logic [emacm_pkg::CFG_ADDR_W-1:0]    paddr,
  input  wire logic [31:0]                         pwdata,
  output logic      [31:0]                         prdata,
  output emacm_pkg::cfg_t                          cfg
);

  logic [31:0] tolerance_r;
  logic [31:0] max_passes_r;
  logic        wr_en;

  assign wr_en = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tolerance_r  <= emacm_pkg::TOLERANCE_RST;
      max_passes_r <= emacm_pkg::MAX_PASSES_RST;
    end else if (wr_en) begin
      unique case (paddr[2])
        emacm_pkg::REG_TOLERANCE:  tolerance_r  <= pwdata;
        emacm_pkg::REG_MAX_PASSES: max_passes_r <= pwdata;
        default:                   tolerance_r  <= tolerance_r;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      emacm_pkg::REG_TOLERANCE:  prdata = tolerance_r;
      emacm_pkg::REG_MAX_PASSES: prdata = max_passes_r;
      default:                   prdata = '0;
    endcase
  end

  assign cfg.tolerance  = tolerance_r;
  assign cfg.max_passes = max_passes_r;

endmodule

`default_nettype wire

// ----- sv/emacm_chan_regs.sv -----
`default_nettype none

module emacm_chan_regs #(
  parameter int CHANNELS = emacm_pkg::CHANNELS_DEF,
  localparam int IDX_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic [IDX_W-1:0]       rd_idx,
  output emacm_pkg::chan_state_t      rd_state,
  input  wire logic                   wr_en,
  input  wire logic                   clr,
  input  wire logic [IDX_W-1:0]       wr_idx,
  input  wire emacm_pkg::chan_state_t wr_state
);

  logic [31:0] ema_r  [CHANNELS];
  logic [31:0] pass_r [CHANNELS];

  // rd_idx may point past CHANNELS only when the word is out of range;
  // then the read value is ignored by the update logic
  always_comb begin
    rd_state = '0;
    for (int i = 0; i < CHANNELS; i++) begin
      if (rd_idx == IDX_W'(i)) begin
        rd_state.ema    = ema_r[i];
        rd_state.passes = pass_r[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || clr) begin
      for (int i = 0; i < CHANNELS; i++) begin
        ema_r[i]  <= '0;
        pass_r[i] <= '0;
      end
    end else if (wr_en) begin
      for (int i = 0; i < CHANNELS; i++) begin
        if (wr_idx == IDX_W'(i)) begin
          ema_r[i]  <= wr_state.ema;
          pass_r[i] <= wr_state.passes;
        end
      end
    end
  end

  // a written channel always leaves with a nonzero pass count
  property p_pass_nonzero;
    @(posedge clk) disable iff (!rst_n)
      (wr_en && !clr) |=> (rd_idx != $past(wr_idx)) || (rd_state.passes != '0);
  endproperty
  a_pass_nonzero: assert property (p_pass_nonzero)
    else $error("channel pass count zero after update");

endmodule

`default_nettype wire

// ----- sv/emacm_update.sv -----
`default_nettype none

module emacm_update #(
  parameter int CHANNELS   = emacm_pkg::CHANNELS_DEF,
  parameter int MIN_PASSES = emacm_pkg::MIN_PASSES_DEF,
  localparam int IDX_W     = (CHANNELS > 1) ? $clog2(CHANNELS) : 1,
  localparam int CH_W      = (IDX_W > 2) ? IDX_W : 2
) (
  input  wire emacm_pkg::in_word_t    word,
  input  wire emacm_pkg::cfg_t        cfg,
  input  wire emacm_pkg::chan_state_t cur_state,
  output logic [IDX_W-1:0]        idx,
  output logic                    chan_wr,
  output logic                    clr,
  output emacm_pkg::chan_state_t  new_state,
  output emacm_pkg::result_t      result
);

  logic [CH_W-1:0]    ch_ext;
  logic               in_range;
  logic signed [32:0] diff;
  logic [32:0]        abs_diff;
  logic [31:0]        res;
  logic [47:0]        prod_new;
  logic [47:0]        prod_old;
  logic [48:0]        acc;
  logic [31:0]        ema;
  logic [31:0]        cnt;
  logic               conv;

  assign ch_ext   = CH_W'(word.channel);
  assign idx      = ch_ext[IDX_W-1:0];
  assign in_range = 32'(word.channel) < 32'(CHANNELS);

  assign clr     = (word.mode == emacm_pkg::MODE_CLEAR);
  assign chan_wr = !clr && in_range;

  // |current - target| always fits in 32 bits
  assign diff     = {word.current_value[31], word.current_value}
                  - {word.target_value[31], word.target_value};
  assign abs_diff = diff[32] ? 33'(-diff) : 33'(diff);
  assign res      = abs_diff[31:0];

  // weights sum to 2^16, so acc stays below 2^48
  assign prod_new = 48'(emacm_pkg::ALPHA_NEW) * 48'(res);
  assign prod_old = 48'(emacm_pkg::ALPHA_OLD) * 48'(cur_state.ema);
  assign acc      = 49'(prod_new) + 49'(prod_old);

  // first sample seeds the average
  assign ema = (cur_state.passes == '0) ? res : acc[47:16];
  assign cnt = (cur_state.passes == '1) ? cur_state.passes : cur_state.passes + 32'd1;

  always_comb begin
    conv = (ema < cfg.tolerance) && (cnt >= 32'(MIN_PASSES));
    if (cnt >= cfg.max_passes) begin
      conv = 1'b1;
    end
  end

  assign new_state.ema    = ema;
  assign new_state.passes = cnt;

  always_comb begin
    result = '0;
    if (chan_wr) begin
      result.converged         = conv;
      result.smoothed_residual = ema;
      result.pass_count        = cnt;
    end
  end

endmodule

`default_nettype wire

// ----- sv/ema_convergence_monitor.sv -----
`default_nettype none

// Channel   Dir  Handshake               Payload
// in_       in   in_tvalid/in_tready     in_tdata (channel, current, target), in_tuser (mode)
// out_      out  out_tvalid/out_tready   out_tdata (converged, smoothed, pass count)
// cfg_      in   APB, pready tied high   tolerance @0x0, max_passes @0x4
//
// One word per cycle sustained while out_tready is high; words pass the input register,
// then the result register. The rate is set by the read-modify-write of the channel
// register file, done between the input register and the result register.
// Synchronous active-low reset restores register defaults and zeroes all channels.
// While out_tready is low one more word is taken into the input register, then in_tready drops.

module ema_convergence_monitor #(
  parameter int CHANNELS   = emacm_pkg::CHANNELS_DEF,
  parameter int MIN_PASSES = emacm_pkg::MIN_PASSES_DEF
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  // input stream
  input  wire logic                                 in_tvalid,
  output logic                                      in_tready,
  // [1:0] channel, [33:2] current_value, [65:34] target_value, [71:66] zero
  input  wire logic [emacm_pkg::IN_TDATA_W-1:0]     in_tdata,
  // [0] mode
  input  wire logic                                 in_tuser,
  // result stream
  output logic                                      out_tvalid,
  input  wire logic                                 out_tready,
  // [0] converged, [32:1] smoothed_residual, [64:33] pass_count, [71:65] zero
  output logic      [emacm_pkg::OUT_TDATA_W-1:0]    out_tdata,
  // configuration
  input  wire logic                                 cfg_psel,
  input  wire logic                                 cfg_penable,
  input  wire logic                                 cfg_pwrite,
  input  wire logic [emacm_pkg::CFG_ADDR_W-1:0]     cfg_paddr,
  input  wire logic [31:0]                          cfg_pwdata,
  output logic      [31:0]                          cfg_prdata,
  output logic                                      cfg_pready
);

  localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  emacm_pkg::cfg_t          cfg;
  emacm_pkg::in_word_t      s1_word_r;
  emacm_pkg::in_word_t      s1_word_nxt;
  logic                     s1_valid_r;
  logic                     s1_valid_nxt;
  logic                     out_valid_r;
  logic                     out_valid_nxt;
  emacm_pkg::result_t       out_res_r;
  emacm_pkg::result_t       res;
  emacm_pkg::chan_state_t   rd_state;
  emacm_pkg::chan_state_t   new_state;
  logic [IDX_W-1:0]         idx;
  logic                     chan_wr;
  logic                     clr;
  logic                     out_free;
  logic                     adv;
  logic                     in_acc;

  assign cfg_pready = 1'b1;

  emacm_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .cfg     (cfg)
  );

  // pipeline control: result register frees when empty or being taken
  assign out_free  = !out_valid_r || out_tready;
  assign adv       = s1_valid_r && out_free;
  assign in_tready = !s1_valid_r || out_free;
  assign in_acc    = in_tvalid && in_tready;

  always_comb begin
    s1_word_nxt.mode          = in_tuser;
    s1_word_nxt.channel       = in_tdata[1:0];
    s1_word_nxt.current_value = in_tdata[33:2];
    s1_word_nxt.target_value  = in_tdata[65:34];
  end

  assign s1_valid_nxt  = in_acc ? 1'b1 : (out_free ? 1'b0 : s1_valid_r);
  assign out_valid_nxt = out_free ? s1_valid_r : out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_word_r <= s1_word_nxt;
    end
    if (adv) begin
      out_res_r <= res;
    end
  end

  emacm_update #(
    .CHANNELS   (CHANNELS),
    .MIN_PASSES (MIN_PASSES)
  ) u_update (
    .word      (s1_word_r),
    .cfg       (cfg),
    .cur_state (rd_state),
    .idx       (idx),
    .chan_wr   (chan_wr),
    .clr       (clr),
    .new_state (new_state),
    .result    (res)
  );

  // state commits on the same edge the word moves to the result register,
  // so the next word in the input register already sees it
  emacm_chan_regs #(
    .CHANNELS (CHANNELS)
  ) u_chan (
    .clk      (clk),
    .rst_n    (rst_n),
    .rd_idx   (idx),
    .rd_state (rd_state),
    .wr_en    (adv && chan_wr),
    .clr      (adv && clr),
    .wr_idx   (idx),
    .wr_state (new_state)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'd0, out_res_r.pass_count, out_res_r.smoothed_residual,
                       out_res_r.converged};

  // clear word always reports all zeros
  property p_clear_zero;
    @(posedge clk) disable iff (!rst_n)
      (adv && s1_word_r.mode == emacm_pkg::MODE_CLEAR) |=> (out_tdata == '0);
  endproperty
  a_clear_zero: assert property (p_clear_zero)
    else $error("clear word produced nonzero result");

  // zero pass count only comes from clear or out-of-range words
  property p_zero_pass;
    @(posedge clk) disable iff (!rst_n)
      (out_tvalid && out_tdata[64:33] == 32'd0) |-> (out_tdata[32:0] == 33'd0);
  endproperty
  a_zero_pass: assert property (p_zero_pass)
    else $error("result with zero pass count carries data");

  // a held word is not dropped while the result register is blocked
  property p_hold_word;
    @(posedge clk) disable iff (!rst_n)
      (s1_valid_r && !adv) |=> s1_valid_r;
  endproperty
  a_hold_word: assert property (p_hold_word)
    else $error("input register word lost under stall");

endmodule

`default_nettype wire

// ----- bench/testbench.sv -----
module testbench;

  // Block build: four channels, three passes before a channel may settle.
  localparam int NUM_CH          = 4;
  localparam int PASS_FLOOR      = 3;
  // Smoothing weights, alpha 0.2 in Q0.16; new + old sums to 1.0.
  localparam logic [63:0] WEIGHT_NEW = 64'd13107;
  localparam logic [63:0] WEIGHT_OLD = 64'd52429;
  // Long receiver hold-off used to back the pipe up into in_tready.
  localparam int HOLD_OFF_CYCLES = 150;
  localparam int SETTLE_CYCLES   = 10;
  localparam int CYCLE_LIMIT     = 300000;
  localparam int PHASE_WORDS     = 273;

  logic clk;
  logic rst_n = 1'b0;

  // input stream; tdata: [1:0] channel, [33:2] current, [65:34] target
  logic                            in_tvalid = 1'b0;
  logic                            in_tready;
  logic [emacm_pkg::IN_TDATA_W-1:0] in_tdata = '0;
  // tuser: [0] mode
  logic                            in_tuser  = 1'b0;
  // result stream; tdata: [0] converged, [32:1] smoothed, [64:33] pass count
  logic                             out_tvalid;
  logic                             out_tready = 1'b0;
  logic [emacm_pkg::OUT_TDATA_W-1:0] out_tdata;
  // APB config port
  logic                            cfg_psel    = 1'b0;
  logic                            cfg_penable = 1'b0;
  logic                            cfg_pwrite  = 1'b0;
  logic [emacm_pkg::CFG_ADDR_W-1:0] cfg_paddr  = '0;
  logic [31:0]                     cfg_pwdata  = '0;
  logic [31:0]                     cfg_prdata;
  logic                            cfg_pready;

  ema_convergence_monitor dut (.*);

  // Words waiting to go out, and verdicts waiting to come back.
  emacm_pkg::in_word_t feed_q[$];
  emacm_pkg::result_t  verdict_q[$];

  // Shadow copy of the block: per-channel smoothed residual and pass count,
  // plus the two config registers as last written over APB.
  logic [31:0] ema_shadow  [NUM_CH];
  logic [31:0] pass_shadow [NUM_CH];
  logic [31:0] tol_shadow        = emacm_pkg::TOLERANCE_RST;
  logic [31:0] max_passes_shadow = emacm_pkg::MAX_PASSES_RST;

  // Per-channel target used to build converging sample runs.
  logic [31:0] aim [NUM_CH] = '{default: '0};

  int unsigned words_queued   = 0;
  int unsigned words_taken    = 0;
  int unsigned mismatches     = 0;
  int unsigned cycles         = 0;
  int unsigned send_idle_pct  = 0;
  int unsigned recv_idle_pct  = 0;
  int unsigned hold_left      = 0;
  bit          hold_off_armed = 1'b0;
  bit          in_fire        = 1'b0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Shadow reset state matches the block after rst_n.
  initial begin
    for (int c = 0; c < NUM_CH; c++) begin
      ema_shadow[c]  = '0;
      pass_shadow[c] = '0;
    end
  end

  // Verdict for one check/clear word; advances the shadow state.
  function automatic emacm_pkg::result_t predict_verdict(emacm_pkg::in_word_t w);
    emacm_pkg::result_t r;
    logic signed [32:0] gap;
    logic [32:0]        mag;
    logic [31:0]        resid;
    logic [31:0]        smooth;
    logic [31:0]        passes;
    logic [63:0]        acc;
    r = '0;
    if (w.mode == emacm_pkg::MODE_CLEAR) begin
      for (int c = 0; c < NUM_CH; c++) begin
        ema_shadow[c]  = '0;
        pass_shadow[c] = '0;
      end
      return r;
    end
    // |current - target| always fits 32 bits unsigned; use 33-bit signed math
    gap   = $signed({w.current_value[31], w.current_value}) -
            $signed({w.target_value[31], w.target_value});
    mag   = gap[32] ? -gap : gap;
    resid = mag[31:0];
    // first sample on a channel loads directly, later ones blend in
    if (pass_shadow[w.channel] == '0) begin
      smooth = resid;
    end else begin
      acc    = WEIGHT_NEW * resid + WEIGHT_OLD * ema_shadow[w.channel];
      smooth = acc[47:16];
    end
    passes = pass_shadow[w.channel];
    if (passes != '1) passes = passes + 1;
    ema_shadow[w.channel]  = smooth;
    pass_shadow[w.channel] = passes;
    r.converged = ((smooth < tol_shadow) && (passes >= PASS_FLOOR)) ||
                  (passes >= max_passes_shadow);
    r.smoothed_residual = smooth;
    r.pass_count        = passes;
    return r;
  endfunction

  function automatic void check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected 0x%08h, got 0x%08h", name, exp_v, act_v);
      mismatches++;
    end
  endfunction

  function automatic logic [31:0] extreme_value();
    case ($urandom_range(3))
      0:       return 32'h8000_0000;
      1:       return 32'h7FFF_FFFF;
      2:       return 32'h0000_0000;
      default: return 32'hFFFF_FFFF;
    endcase
  endfunction

  // Mostly converging runs around a per-channel target, some raw noise,
  // some rail values, and the odd clear.
  function automatic emacm_pkg::in_word_t random_word();
    emacm_pkg::in_word_t w;
    int unsigned pick;
    int unsigned span;
    logic [31:0] offset;
    pick            = $urandom_range(99);
    w.mode          = emacm_pkg::MODE_CHECK;
    w.channel       = 2'($urandom_range(NUM_CH - 1));
    w.current_value = $urandom;
    w.target_value  = $urandom;
    if (pick < 3) begin
      w.mode = emacm_pkg::MODE_CLEAR;
    end else if (pick < 68) begin
      if ($urandom_range(9) == 0) aim[w.channel] = $urandom;
      span   = 1 << $urandom_range(14);
      offset = $urandom_range(span - 1);
      if ($urandom_range(1) == 1) offset = -offset;
      w.target_value  = aim[w.channel];
      w.current_value = aim[w.channel] + offset;
    end else if (pick >= 88) begin
      w.current_value = extreme_value();
      w.target_value  = extreme_value();
    end
    return w;
  endfunction

  // Queue pushes happen just after a rising edge so they never race the driver.
  task automatic queue_word(logic mode, logic [1:0] ch, logic [31:0] cur, logic [31:0] tgt);
    emacm_pkg::in_word_t w;
    w.mode          = mode;
    w.channel       = ch;
    w.current_value = cur;
    w.target_value  = tgt;
    feed_q.push_back(w);
    words_queued++;
  endtask

  task automatic queue_random(int unsigned n);
    @(posedge clk);
    repeat (n) begin
      feed_q.push_back(random_word());
      words_queued++;
    end
  endtask

  // Counters move at the rising edge, so poll them at the falling one.
  task automatic wait_drained();
    do @(negedge clk); while (words_taken != words_queued || verdict_q.size() != 0);
  endtask

  task automatic apb_write(logic reg_sel, logic [31:0] data);
    @(negedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {reg_sel, 2'b00};
    cfg_pwdata  <= data;
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
  endtask

  // One phase: program both registers while idle, then two bursts of random
  // words with a full drain in between (sender sits idle until all is back).
  task automatic run_phase(int unsigned send_pct, int unsigned recv_pct,
                           logic [31:0] tol, logic [31:0] maxp, bit with_hold);
    apb_write(emacm_pkg::REG_TOLERANCE, tol);
    apb_write(emacm_pkg::REG_MAX_PASSES, maxp);
    @(posedge clk);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    queue_random(PHASE_WORDS / 2);
    // receiver goes dark while the sender keeps offering: pipe fills, in_tready drops
    if (with_hold) hold_off_armed = 1'b1;
    wait_drained();
    queue_random(PHASE_WORDS - PHASE_WORDS / 2);
    wait_drained();
  endtask

  // Sequencer
  initial begin
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed words at reset config (tolerance 655, max passes 100).
    @(posedge clk);
    send_idle_pct = 37;
    recv_idle_pct = 73;
    // largest residual, loaded then blended with itself, then decayed
    queue_word(emacm_pkg::MODE_CHECK, 2'd0, 32'h7FFF_FFFF, 32'h8000_0000);
    queue_word(emacm_pkg::MODE_CHECK, 2'd0, 32'h8000_0000, 32'h7FFF_FFFF);
    queue_word(emacm_pkg::MODE_CHECK, 2'd0, 32'h0000_0000, 32'h0000_0000);
    // zero residual: converges on the third pass
    queue_word(emacm_pkg::MODE_CHECK, 2'd1, 32'h0000_0000, 32'h0000_0000);
    queue_word(emacm_pkg::MODE_CHECK, 2'd1, 32'h0000_0000, 32'h0000_0000);
    queue_word(emacm_pkg::MODE_CHECK, 2'd1, 32'h0000_0000, 32'h0000_0000);
    // negative minus positive
    queue_word(emacm_pkg::MODE_CHECK, 2'd2, 32'hFFFF_FFFB, 32'h0000_0005);
    queue_word(emacm_pkg::MODE_CHECK, 2'd2, 32'h1234_5678, 32'hFEDC_BA98);
    // residual equal to tolerance never counts as converged
    queue_word(emacm_pkg::MODE_CHECK, 2'd3, 32'd655, 32'd0);
    queue_word(emacm_pkg::MODE_CHECK, 2'd3, 32'd655, 32'd0);
    queue_word(emacm_pkg::MODE_CHECK, 2'd3, 32'd655, 32'd0);
    // clear, then first sample reloads; one below tolerance converges
    queue_word(emacm_pkg::MODE_CLEAR, 2'd3, $urandom, $urandom);
    queue_word(emacm_pkg::MODE_CHECK, 2'd3, 32'd654, 32'd0);
    queue_word(emacm_pkg::MODE_CHECK, 2'd3, 32'd0, 32'd654);
    queue_word(emacm_pkg::MODE_CHECK, 2'd3, 32'd0, 32'd654);
    wait_drained();

    // sender idles 37%, receiver 73%
    run_phase(37, 73, 32'd655, 32'd100, 1'b0);
    run_phase(37, 73, 32'd1, 32'd0, 1'b0);
    // roles swapped
    run_phase(73, 37, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
    run_phase(73, 37, $urandom_range(4096, 256), $urandom_range(12, 3), 1'b0);
    // no idling, plus the long receiver hold-off
    run_phase(0, 0, $urandom_range(32'hFFFF_FFFF, 1), $urandom_range(200, 20), 1'b1);
    run_phase(0, 0, 32'h0001_0000, 32'd100, 1'b0);

    repeat (SETTLE_CYCLES) @(negedge clk);
    if (mismatches == 0 && verdict_q.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // Driver: hold a word until taken, then maybe pull the next one.
  always @(negedge clk) begin : feed_driver
    emacm_pkg::in_word_t w;
    if (!rst_n || (in_tvalid && !in_fire)) begin
      // word still on the bus (or in reset)
    end else if (feed_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
      w = feed_q.pop_front();
      in_tdata  <= {6'b0, w.target_value, w.current_value, w.channel};
      in_tuser  <= w.mode;
      in_tvalid <= 1'b1;
    end else begin
      in_tvalid <= 1'b0;
    end
  end

  // Receiver back-pressure; the hold-off length is counted here.
  always @(negedge clk) begin
    if (hold_off_armed) begin
      hold_left      = HOLD_OFF_CYCLES;
      hold_off_armed = 1'b0;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Monitor: snoop config writes, predict on input accept, check on output.
  always @(posedge clk) begin : verdict_monitor
    emacm_pkg::in_word_t w;
    emacm_pkg::result_t  exp_r;
    in_fire = 1'b0;
    if (rst_n) begin
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
        if (cfg_paddr[2] == emacm_pkg::REG_TOLERANCE) tol_shadow = cfg_pwdata;
        else max_passes_shadow = cfg_pwdata;
      end
      in_fire = in_tvalid && in_tready;
      if (in_fire) begin
        w.mode          = in_tuser;
        w.channel       = in_tdata[1:0];
        w.current_value = in_tdata[33:2];
        w.target_value  = in_tdata[65:34];
        verdict_q.push_back(predict_verdict(w));
        words_taken++;
      end
      if (out_tvalid && out_tready) begin
        if (verdict_q.size() == 0) begin
          $error("unexpected result word 0x%018h", out_tdata);
          mismatches++;
        end else begin
          exp_r = verdict_q.pop_front();
          check_field("converged", 32'(exp_r.converged), 32'(out_tdata[0]));
          check_field("smoothed_residual", exp_r.smoothed_residual, out_tdata[32:1]);
          check_field("pass_count", exp_r.pass_count, out_tdata[64:33]);
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

endmodule
